// ===== hw/rtl/tps_pkg.sv =====
package tps_pkg;

  localparam int MaxSlices = 64;
  localparam int CntW = $clog2(MaxSlices + 1);
  localparam int FracBits = 16;
  localparam logic [30:0] SpacingReset = 31'(1 << FracBits);
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    REG_SPACING,
    REG_LOWER,
    REG_UPPER,
    REG_REGION
  } reg_idx_t;

  typedef struct packed {
    logic [30:0]        spacing;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    logic               region_en;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0]      ax;
    logic signed [31:0]      ay;
    logic signed [31:0]      az;
    logic signed [31:0]      bx;
    logic signed [31:0]      by_coord;
    logic signed [31:0]      bz;
    logic signed [31:0]      cx;
    logic signed [31:0]      cy;
    logic signed [31:0]      cz;
    logic signed [31:0]      region;
    logic signed [32:0]      first;
    logic [CntW-1:0]         count;
    logic                    trunc;
    logic signed [33:0]      d0;
    logic [30:0]             spacing;
    logic                    ny_pos;
    logic                    ny_neg;
  } job_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [15:0] slice_index;
    logic signed [31:0] seg_region;
    logic               last_of_triangle;
    logic               truncated;
  } seg_t;

  function automatic logic signed [32:0] sdiff33(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return $signed({a[31], a}) - $signed({b[31], b});
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] a;
    a = v[32] ? -v : v;
    return a[31:0];
  endfunction

endpackage

// ===== hw/rtl/tps_tri_if.sv =====
interface tps_tri_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [31:0] az;
  logic signed [31:0] bx;
  logic signed [31:0] by_coord;
  logic signed [31:0] bz;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cz;
  logic signed [31:0] tri_region;

  modport source(output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, tri_region,
                 input ready);
  modport sink(input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, tri_region,
               output ready);
endinterface

// ===== hw/rtl/tps_seg_if.sv =====
interface tps_seg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic signed [15:0] slice_index;
  logic signed [31:0] seg_region;
  logic               last_of_triangle;
  logic               truncated;

  modport source(output valid, start_x, start_y, start_z, end_x, end_y, end_z, slice_index,
                 seg_region, last_of_triangle, truncated, input ready);
  modport sink(input valid, start_x, start_y, start_z, end_x, end_y, end_z, slice_index,
               seg_region, last_of_triangle, truncated, output ready);
endinterface

// ===== hw/rtl/tps_front.sv =====
module tps_front
  import tps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tps_tri_if.sink    tri_in,
  input  cfg_t       cfg,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  typedef enum logic [2:0] {F_IDLE, F_EVAL, F_DIV, F_FINISH, F_PUSH} fstate_t;

  fstate_t            state;
  logic               div_sel;
  logic [4:0]         div_cnt;
  logic [31:0]        div_rem;
  logic [31:0]        div_quo;
  logic               div_neg;
  logic signed [31:0] zlo;
  logic signed [32:0] q_lo;
  logic signed [32:0] q_hi;
  logic signed [31:0] r_lo;
  logic [63:0]        m1;
  logic [63:0]        m2;
  logic               n1;
  logic               n2;

  logic [30:0]        s_eff;
  logic signed [31:0] zmin;
  logic signed [31:0] zmax;
  logic signed [31:0] zlo_c;
  logic signed [31:0] zhi_c;
  logic               reject;
  logic [31:0]        div_shift;
  logic               div_ge;
  logic [31:0]        rem_next;
  logic [31:0]        quo_next;
  logic signed [32:0] q_c;
  logic signed [31:0] r_c;
  logic signed [32:0] ab_z;
  logic signed [32:0] ac_x;
  logic signed [32:0] ab_x;
  logic signed [32:0] ac_z;
  logic signed [33:0] diff;
  logic               n1m;
  logic               n2m;
  logic               ny_zero;
  logic               ny_pos;

  assign tri_in.ready = (state == F_IDLE);
  assign job_valid = (state == F_PUSH);

  always_comb begin
    s_eff = (cfg.spacing == '0) ? 31'd1 : cfg.spacing;
    zmin = job.az;
    if (job.bz < zmin) zmin = job.bz;
    if (job.cz < zmin) zmin = job.cz;
    zmax = job.az;
    if (job.bz > zmax) zmax = job.bz;
    if (job.cz > zmax) zmax = job.cz;
    reject = (zmin > cfg.upper) || (zmax < cfg.lower);
    zlo_c = (zmin < cfg.lower) ? cfg.lower : zmin;
    zhi_c = (zmax > cfg.upper) ? cfg.upper : zmax;

    div_shift = {div_rem[30:0], div_quo[31]};
    div_ge = (div_shift >= {1'b0, s_eff});
    rem_next = div_ge ? (div_shift - {1'b0, s_eff}) : div_shift;
    quo_next = {div_quo[30:0], div_ge};
    q_c = div_neg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
    r_c = div_neg ? -$signed(rem_next) : $signed(rem_next);

    ab_z = sdiff33(job.bz, job.az);
    ac_x = sdiff33(job.cx, job.ax);
    ab_x = sdiff33(job.bx, job.ax);
    ac_z = sdiff33(job.cz, job.az);

    diff = $signed({q_hi[32], q_hi}) - $signed({q_lo[32], q_lo});

    n1m = n1 && (m1 != '0);
    n2m = n2 && (m2 != '0);
    ny_zero = 1'b0;
    ny_pos = 1'b0;
    if (n1m != n2m) begin
      ny_pos = !n1m;
    end else if (m1 == m2) begin
      ny_zero = 1'b1;
    end else if (!n1m) begin
      ny_pos = (m1 > m2);
    end else begin
      ny_pos = (m1 < m2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (tri_in.valid) begin
            job.ax <= tri_in.ax;
            job.ay <= tri_in.ay;
            job.az <= tri_in.az;
            job.bx <= tri_in.bx;
            job.by_coord <= tri_in.by_coord;
            job.bz <= tri_in.bz;
            job.cx <= tri_in.cx;
            job.cy <= tri_in.cy;
            job.cz <= tri_in.cz;
            job.region <= cfg.region_en ? tri_in.tri_region : '0;
            state <= F_EVAL;
          end
        end
        F_EVAL: begin
          if (reject) begin
            state <= F_IDLE;
          end else begin
            zlo <= zlo_c;
            q_hi <= sdiff33(zhi_c, 32'sd0);
            div_sel <= 1'b0;
            div_cnt <= '0;
            div_rem <= '0;
            div_neg <= zlo_c[31];
            div_quo <= zlo_c[31] ? 32'(-zlo_c) : 32'(zlo_c);
            m1 <= mag33(ab_z) * mag33(ac_x);
            m2 <= mag33(ab_x) * mag33(ac_z);
            n1 <= ab_z[32] ^ ac_x[32];
            n2 <= ab_x[32] ^ ac_z[32];
            state <= F_DIV;
          end
        end
        F_DIV: begin
          div_cnt <= div_cnt + 5'd1;
          div_rem <= rem_next;
          div_quo <= quo_next;
          if (div_cnt == 5'd31) begin
            div_cnt <= '0;
            if (!div_sel) begin
              q_lo <= q_c;
              r_lo <= r_c;
              div_sel <= 1'b1;
              div_rem <= '0;
              div_neg <= q_hi[31];
              div_quo <= q_hi[31] ? 32'(-q_hi[31:0]) : q_hi[31:0];
            end else begin
              q_hi <= q_c;
              state <= F_FINISH;
            end
          end
        end
        F_FINISH: begin
          if (diff[33]) begin
            state <= F_IDLE;
          end else begin
            job.first <= q_lo;
            job.trunc <= (diff >= 34'(MaxSlices));
            job.count <= (diff >= 34'(MaxSlices)) ? CntW'(MaxSlices) : CntW'(diff + 34'sd1);
            job.d0 <= $signed({{2{zlo[31]}}, zlo}) - $signed({{2{r_lo[31]}}, r_lo});
            job.spacing <= s_eff;
            job.ny_pos <= ny_pos;
            job.ny_neg <= !ny_pos && !ny_zero;
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (job_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tps_queue.sv =====
module tps_queue
  import tps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  localparam int PtrW = $clog2(QueueDepth);

  job_t                   mem [QueueDepth];
  logic [PtrW-1:0]        wptr;
  logic [PtrW-1:0]        rptr;
  logic [PtrW:0]          count;
  logic                   do_wr;
  logic                   do_rd;

  assign wr_ready = (count != (PtrW + 1)'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_data = mem[rptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        mem[wptr] <= wr_data;
        wptr <= (wptr == PtrW'(QueueDepth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PtrW'(QueueDepth - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PtrW + 1)'(do_wr) - (PtrW + 1)'(do_rd);
    end
  end

endmodule

// ===== hw/rtl/tps_back.sv =====
module tps_back
  import tps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  output logic       job_ready,
  input  job_t       job,
  tps_seg_if.source  seg_out
);

  typedef enum logic [2:0] {B_IDLE, B_PLANE, B_MUL, B_DIV, B_FORM, B_EMIT, B_FLUSH} bstate_t;
  typedef enum logic [1:0] {HIT_NONE, HIT_CROSS, HIT_CORNER} hit_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vtx_t;

  bstate_t            state;
  job_t               jr;
  logic [CntW-1:0]    k;
  logic signed [32:0] j;
  logic signed [33:0] d;
  logic [1:0]         e0;
  logic [1:0]         e1;
  logic               two_cross;
  logic               ci;
  logic               coord;
  logic signed [31:0] pt0x;
  logic signed [31:0] pt0y;
  logic signed [31:0] pt1x;
  logic signed [31:0] pt1y;
  logic [31:0]        rem;
  logic [31:0]        low;
  logic [31:0]        rise_r;
  logic               neg_r;
  logic signed [31:0] base_r;
  logic [4:0]         div_cnt;
  seg_t               nseg;
  seg_t               pend;
  logic               pend_valid;
  seg_t               outr;
  logic               out_valid;

  vtx_t               eq [3];
  vtx_t               er [3];
  vtx_t               lo_v [3];
  vtx_t               hi_v [3];
  logic [31:0]        rise [3];
  logic signed [34:0] lift [3];
  hit_t               kind [3];
  vtx_t               cpt [3];
  logic [1:0]         cut;
  logic [1:0]         cx0;
  logic [1:0]         cx1;
  logic               corner_any;
  vtx_t               corner_pt;
  logic [1:0]         es;
  logic signed [31:0] lo_c;
  logic signed [31:0] hi_c;
  logic signed [32:0] delta;
  logic [32:0]        div_shift;
  logic               div_ge;
  logic [31:0]        rem_next;
  logic [31:0]        low_next;
  logic signed [31:0] res;
  logic signed [32:0] dx;
  logic               swap;
  logic signed [15:0] idx_sat;
  logic               out_free;
  logic               plane_done;

  assign job_ready = (state == B_IDLE);
  assign out_free = !out_valid || seg_out.ready;

  assign seg_out.valid = out_valid;
  assign seg_out.start_x = outr.start_x;
  assign seg_out.start_y = outr.start_y;
  assign seg_out.start_z = outr.start_z;
  assign seg_out.end_x = outr.end_x;
  assign seg_out.end_y = outr.end_y;
  assign seg_out.end_z = outr.end_z;
  assign seg_out.slice_index = outr.slice_index;
  assign seg_out.seg_region = outr.seg_region;
  assign seg_out.last_of_triangle = outr.last_of_triangle;
  assign seg_out.truncated = outr.truncated;

  always_comb begin
    eq[0] = '{jr.ax, jr.ay, jr.az};
    er[0] = '{jr.bx, jr.by_coord, jr.bz};
    eq[1] = '{jr.ax, jr.ay, jr.az};
    er[1] = '{jr.cx, jr.cy, jr.cz};
    eq[2] = '{jr.bx, jr.by_coord, jr.bz};
    er[2] = '{jr.cx, jr.cy, jr.cz};
    for (int e = 0; e < 3; e++) begin
      lo_v[e] = (eq[e].z > er[e].z) ? er[e] : eq[e];
      hi_v[e] = (eq[e].z > er[e].z) ? eq[e] : er[e];
      rise[e] = 32'(sdiff33(hi_v[e].z, lo_v[e].z));
      lift[e] = $signed({d[33], d}) - $signed({{3{lo_v[e].z[31]}}, lo_v[e].z});
      cpt[e] = (lift[e] == '0) ? lo_v[e] : hi_v[e];
      if (rise[e] == '0) begin
        kind[e] = HIT_NONE;
      end else if (lift[e] == '0 || lift[e] == $signed({3'b0, rise[e]})) begin
        kind[e] = HIT_CORNER;
      end else if (lift[e] < 0 || lift[e] > $signed({3'b0, rise[e]})) begin
        kind[e] = HIT_NONE;
      end else begin
        kind[e] = HIT_CROSS;
      end
    end

    cut = '0;
    cx0 = '0;
    cx1 = '0;
    corner_any = 1'b0;
    corner_pt = '0;
    for (int e = 0; e < 3; e++) begin
      if (kind[e] == HIT_CROSS) begin
        if (cut == 2'd0) cx0 = 2'(e);
        else if (cut == 2'd1) cx1 = 2'(e);
        cut = cut + 2'd1;
      end else if (kind[e] == HIT_CORNER) begin
        corner_any = 1'b1;
        corner_pt = cpt[e];
      end
    end

    es = ci ? e1 : e0;
    lo_c = coord ? lo_v[es].y : lo_v[es].x;
    hi_c = coord ? hi_v[es].y : hi_v[es].x;
    delta = sdiff33(hi_c, lo_c);

    div_shift = {rem, low[31]};
    div_ge = (div_shift >= {1'b0, rise_r});
    rem_next = div_ge ? 32'(div_shift - {1'b0, rise_r}) : div_shift[31:0];
    low_next = {low[30:0], div_ge};
    res = base_r + (neg_r ? -$signed(low_next) : $signed(low_next));

    dx = sdiff33(pt0x, pt1x);
    swap = (jr.ny_pos && dx < 0) || (jr.ny_neg && dx > 0);
    if (j > 33'sd32767) idx_sat = 16'sd32767;
    else if (j < -33'sd32768) idx_sat = -16'sd32768;
    else idx_sat = j[15:0];

    plane_done = ((state == B_PLANE) && !(cut == 2'd2 || (cut == 2'd1 && corner_any)))
              || ((state == B_EMIT) && (!pend_valid || out_free));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && seg_out.ready) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            jr <= job;
            k <= '0;
            j <= job.first;
            d <= job.d0;
            state <= B_PLANE;
          end
        end
        B_PLANE: begin
          e0 <= cx0;
          e1 <= cx1;
          ci <= 1'b0;
          coord <= 1'b0;
          two_cross <= (cut == 2'd2);
          pt1x <= corner_pt.x;
          pt1y <= corner_pt.y;
          if (cut == 2'd2 || (cut == 2'd1 && corner_any)) state <= B_MUL;
        end
        B_MUL: begin
          {rem, low} <= mag33(delta) * lift[es][31:0];
          neg_r <= delta[32];
          base_r <= lo_c;
          rise_r <= rise[es];
          div_cnt <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          rem <= rem_next;
          low <= low_next;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            case ({ci, coord})
              2'b00: pt0x <= res;
              2'b01: pt0y <= res;
              2'b10: pt1x <= res;
              default: pt1y <= res;
            endcase
            if (!coord) begin
              coord <= 1'b1;
              state <= B_MUL;
            end else if (!ci && two_cross) begin
              ci <= 1'b1;
              coord <= 1'b0;
              state <= B_MUL;
            end else begin
              state <= B_FORM;
            end
          end
        end
        B_FORM: begin
          nseg.start_x <= swap ? pt1x : pt0x;
          nseg.start_y <= swap ? pt1y : pt0y;
          nseg.end_x <= swap ? pt0x : pt1x;
          nseg.end_y <= swap ? pt0y : pt1y;
          nseg.start_z <= d[31:0];
          nseg.end_z <= d[31:0];
          nseg.slice_index <= idx_sat;
          nseg.seg_region <= jr.region;
          nseg.last_of_triangle <= 1'b0;
          nseg.truncated <= jr.trunc;
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (!pend_valid) begin
            pend <= nseg;
            pend_valid <= 1'b1;
          end else if (out_free) begin
            outr <= pend;
            out_valid <= 1'b1;
            pend <= nseg;
          end
        end
        B_FLUSH: begin
          if (!pend_valid) begin
            state <= B_IDLE;
          end else if (out_free) begin
            outr <= pend;
            outr.last_of_triangle <= 1'b1;
            out_valid <= 1'b1;
            pend_valid <= 1'b0;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
      if (plane_done) begin
        if (CntW'(k + 1'b1) == jr.count) begin
          state <= B_FLUSH;
        end else begin
          k <= k + 1'b1;
          j <= j + 33'sd1;
          d <= d + $signed({3'b0, jr.spacing});
          state <= B_PLANE;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE) |-> !pend_valid) else $error("segment left pending at idle");
  a_flat_segment: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (outr.start_z == outr.end_z)) else $error("segment not on one plane");
  a_plane_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_PLANE) |-> (k < jr.count)) else $error("plane counter overrun");
`endif

endmodule

// ===== hw/rtl/triangle_plane_slicer_core.sv =====
// triangle plane slicer
// tri_in takes one triangle per transfer (three Q16.16 vertices and a region id);
// seg_out gives one line segment per slice plane that cuts it, last_of_triangle
// marks the final segment of a triangle. triangles that yield nothing give no transfer.
// registers sit on an APB-style port: spacing, lower bound, upper bound, region enable.
// the front stage handles each triangle in turn: accept, z range and bound test, two
// 32-step serial divisions for the first and last plane index, finish and hand over.
// the back stage walks the planes one at a time: it classifies a plane, then computes
// each interpolated coordinate with one multiply and a 32-step serial divide, 2 or 4
// coordinates per cutting plane, and at last orders and emits the segment.
// a two-entry job queue lets the front take new triangles while the back still works.
// one segment is held back until the next one or the end of the triangle is known,
// so the first segment leaves after the second plane result or the triangle end.
// when seg_out is stalled the back stage waits and the queue then fills and stalls tri_in.
// reset returns spacing to 1.0, bounds and region enable to zero, and empties all stages.
module triangle_plane_slicer_core
  import tps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tps_tri_if.sink     tri_in,
  tps_seg_if.source   seg_out
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     f_valid;
  logic     f_ready;
  job_t     f_job;
  logic     b_valid;
  logic     b_ready;
  job_t     b_job;

  assign pready = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (reg_idx)
      REG_SPACING: prdata = {1'b0, cfg.spacing};
      REG_LOWER:   prdata = cfg.lower;
      REG_UPPER:   prdata = cfg.upper;
      REG_REGION:  prdata = {31'b0, cfg.region_en};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spacing <= SpacingReset;
      cfg.lower <= '0;
      cfg.upper <= '0;
      cfg.region_en <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_SPACING: cfg.spacing <= pwdata[30:0];
        REG_LOWER:   cfg.lower <= pwdata;
        REG_UPPER:   cfg.upper <= pwdata;
        REG_REGION:  cfg.region_en <= pwdata[0];
        default:     cfg.region_en <= cfg.region_en;
      endcase
    end
  end

  tps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tri_in    (tri_in),
    .cfg       (cfg),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  tps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_job),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_job)
  );

  tps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .seg_out   (seg_out)
  );

endmodule

// ===== tb/tb_triangle_plane_slicer_core.sv =====
`timescale 1ns / 100ps
module tb_triangle_plane_slicer_core
  import tps_pkg::*;
();

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tps_tri_if tri_in();
  tps_seg_if seg_out();

  triangle_plane_slicer_core dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .tri_in(tri_in.sink), .seg_out(seg_out.source)
  );

  typedef struct {
    logic signed [31:0] v[9];
    logic signed [31:0] region;
  } tri_t;

  typedef struct {
    tri_t    t;
    bit      has_exp;
    seg_t    exp_seg;
  } row_t;

  longint unsigned spacing_m;
  longint          lower_m;
  longint          upper_m;
  bit              region_en_m;

  seg_t seg_q[$];
  int   fail_cnt;
  int   send_idle_pct;
  int   recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint lerp_off(longint delta, longint num, longint den);
    longint unsigned quo;
    quo = (mag64(delta) * longint'(num)) / longint'(den);
    return delta < 0 ? -longint'(quo) : longint'(quo);
  endfunction

  // 0 none, 1 crossing, 2 corner
  function automatic int edge_cut(longint d, longint q[3], longint r[3],
                                  output longint px, output longint py);
    longint lo[3];
    longint hi[3];
    longint rise;
    longint lift;
    lo = q;
    hi = r;
    px = 0;
    py = 0;
    if (q[2] > r[2]) begin
      lo = r;
      hi = q;
    end
    rise = hi[2] - lo[2];
    if (rise == 0) return 0;
    lift = d - lo[2];
    if (lift == 0) begin
      px = lo[0];
      py = lo[1];
      return 2;
    end
    if (lift == rise) begin
      px = hi[0];
      py = hi[1];
      return 2;
    end
    if (lift < 0 || lift > rise) return 0;
    px = lo[0] + lerp_off(hi[0] - lo[0], lift, rise);
    py = lo[1] + lerp_off(hi[1] - lo[1], lift, rise);
    return 1;
  endfunction

  function automatic int prod_sign(longint a, longint b, longint c, longint d);
    longint unsigned m1;
    longint unsigned m2;
    bit n1;
    bit n2;
    m1 = mag64(a) * mag64(b);
    m2 = mag64(c) * mag64(d);
    n1 = (m1 != 0) && ((a < 0) != (b < 0));
    n2 = (m2 != 0) && ((c < 0) != (d < 0));
    if (n1 != n2) return n1 ? -1 : 1;
    if (m1 == m2) return 0;
    if (!n1) return m1 > m2 ? 1 : -1;
    return m1 > m2 ? -1 : 1;
  endfunction

  function automatic void predict_segments(tri_t t);
    longint va[3];
    longint vb[3];
    longint vc[3];
    longint eq[3][3];
    longint er[3][3];
    longint pts[3][2];
    longint crn[2];
    longint s, zmin, zmax, lo, hi, first, last, span, j, d, dx, px, py, idx, tmp;
    int ny, cut, h, e;
    bit corner_hit, trunc;
    seg_t sg;
    seg_t segs[$];
    for (int k = 0; k < 3; k++) begin
      va[k] = longint'(t.v[k]);
      vb[k] = longint'(t.v[3 + k]);
      vc[k] = longint'(t.v[6 + k]);
    end
    s = spacing_m == 0 ? 1 : longint'(spacing_m);
    zmin = va[2] < vb[2] ? va[2] : vb[2];
    if (vc[2] < zmin) zmin = vc[2];
    zmax = va[2] > vb[2] ? va[2] : vb[2];
    if (vc[2] > zmax) zmax = vc[2];
    if (zmin > upper_m || zmax < lower_m) return;
    lo = zmin < lower_m ? lower_m : zmin;
    hi = zmax > upper_m ? upper_m : zmax;
    first = lo / s;
    last = hi / s;
    if (first < lower_m / s) first = lower_m / s;
    if (last > upper_m / s) last = upper_m / s;
    if (first > last) return;
    span = last - first + 1;
    trunc = span > MaxSlices;
    if (trunc) span = MaxSlices;
    ny = prod_sign(vb[2] - va[2], vc[0] - va[0], vb[0] - va[0], vc[2] - va[2]);
    eq[0] = va; er[0] = vb;
    eq[1] = va; er[1] = vc;
    eq[2] = vb; er[2] = vc;
    for (j = first; j < first + span; j++) begin
      d = s * j;
      cut = 0;
      corner_hit = 0;
      for (e = 0; e < 3; e++) begin
        h = edge_cut(d, eq[e], er[e], px, py);
        if (h == 1) begin
          pts[cut][0] = px;
          pts[cut][1] = py;
          cut++;
        end else if (h == 2) begin
          corner_hit = 1;
          crn[0] = px;
          crn[1] = py;
        end
      end
      if (cut == 1 && corner_hit) begin
        pts[1] = crn;
        cut = 2;
      end
      if (cut != 2) continue;
      dx = pts[0][0] - pts[1][0];
      if ((ny > 0 && dx < 0) || (ny < 0 && dx > 0)) begin
        for (int k = 0; k < 2; k++) begin
          tmp = pts[0][k];
          pts[0][k] = pts[1][k];
          pts[1][k] = tmp;
        end
      end
      idx = j > 32767 ? 32767 : (j < -32768 ? -32768 : j);
      sg.start_x = 32'(pts[0][0]);
      sg.start_y = 32'(pts[0][1]);
      sg.start_z = 32'(d);
      sg.end_x = 32'(pts[1][0]);
      sg.end_y = 32'(pts[1][1]);
      sg.end_z = 32'(d);
      sg.slice_index = 16'(idx);
      sg.seg_region = region_en_m ? t.region : 32'sd0;
      sg.last_of_triangle = 1'b0;
      sg.truncated = trunc;
      segs = {segs, sg};
    end
    if (segs.size() > 0) segs[segs.size() - 1].last_of_triangle = 1'b1;
    seg_q = {seg_q, segs};
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(4 * int'(idx));
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_SPACING: spacing_m = 64'(val[30:0]);
      REG_LOWER: lower_m = longint'($signed(val));
      REG_UPPER: upper_m = longint'($signed(val));
      default: region_en_m = val[0];
    endcase
  endtask

  task automatic send_tri(tri_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      tri_in.valid <= 1'b0;
      @(negedge clk);
    end
    tri_in.valid <= 1'b1;
    tri_in.ax <= t.v[0];
    tri_in.ay <= t.v[1];
    tri_in.az <= t.v[2];
    tri_in.bx <= t.v[3];
    tri_in.by_coord <= t.v[4];
    tri_in.bz <= t.v[5];
    tri_in.cx <= t.v[6];
    tri_in.cy <= t.v[7];
    tri_in.cz <= t.v[8];
    tri_in.tri_region <= t.region;
    do @(posedge clk); while (!tri_in.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    tri_in.valid <= 1'b0;
    while (seg_q.size() != 0) @(negedge clk);
    repeat (3000) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) seg_out.ready <= 1'b0;
    else seg_out.ready <= $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk) begin
    seg_t got;
    seg_t want;
    if (!rst && seg_out.valid && seg_out.ready) begin
      got.start_x = seg_out.start_x;
      got.start_y = seg_out.start_y;
      got.start_z = seg_out.start_z;
      got.end_x = seg_out.end_x;
      got.end_y = seg_out.end_y;
      got.end_z = seg_out.end_z;
      got.slice_index = seg_out.slice_index;
      got.seg_region = seg_out.seg_region;
      got.last_of_triangle = seg_out.last_of_triangle;
      got.truncated = seg_out.truncated;
      if (seg_q.size() == 0) begin
        $display("%0t unexpected segment: expected none, actual %p", $time, got);
        fail_cnt++;
      end else begin
        want = seg_q.pop_front();
        if (got !== want) begin
          $display("%0t segment mismatch: expected %p, actual %p", $time, want, got);
          fail_cnt++;
        end
      end
    end
  end

  function automatic tri_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz, int rg);
    tri_t t;
    t.v[0] = ax; t.v[1] = ay; t.v[2] = az;
    t.v[3] = bx; t.v[4] = by; t.v[5] = bz;
    t.v[6] = cx; t.v[7] = cy; t.v[8] = cz;
    t.region = rg;
    return t;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(20)) - 10) << 16;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    int zr;
    zr = $urandom_range(3);
    for (int k = 0; k < 9; k++) begin
      if (k % 3 != 2 || zr == 0) t.v[k] = rand_word();
      else if (zr == 1) t.v[k] = $signed($urandom_range(6 << 16)) - (3 << 16);
      else if (zr == 2) t.v[k] = ($signed($urandom_range(6)) - 3) <<< 16;
      else t.v[k] = $signed($urandom_range(40 << 16)) - (20 << 16);
    end
    t.region = $urandom;
    return t;
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    tri_t t;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) begin
      t = rand_tri();
      predict_segments(t);
      send_tri(t);
    end
    drain();
  endtask

  initial begin
    row_t rows[$];
    row_t r;
    seg_t e;
    fail_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tri_in.valid = 1'b0;
    tri_in.ax = '0; tri_in.ay = '0; tri_in.az = '0;
    tri_in.bx = '0; tri_in.by_coord = '0; tri_in.bz = '0;
    tri_in.cx = '0; tri_in.cy = '0; tri_in.cz = '0;
    tri_in.tri_region = '0;
    spacing_m = 65536;
    lower_m = 0;
    upper_m = 0;
    region_en_m = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset config: only plane z = 0
    r.t = make_tri(0, 0, -65536, 65536, 0, 65536, 0, 65536, 65536, 5);
    r.has_exp = 1;
    e.start_x = 0; e.start_y = 32768; e.start_z = 0;
    e.end_x = 32768; e.end_y = 0; e.end_z = 0;
    e.slice_index = 0; e.seg_region = 0; e.last_of_triangle = 1; e.truncated = 0;
    r.exp_seg = e;
    rows = {rows, r};
    r.has_exp = 0;
    rows = {rows, r};
    // above, below, flat, corner only, corner with one crossing
    rows = {rows, row_t'{make_tri(0, 0, 65536, 1, 1, 65536, 2, 0, 131072, 1), 0, e}};
    rows = {rows, row_t'{make_tri(0, 0, -65536, 1, 1, -65536, 2, 0, -1, 1), 0, e}};
    rows = {rows, row_t'{make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 2), 0, e}};
    rows = {rows, row_t'{make_tri(0, 0, 0, 65536, 0, 65536, 0, 65536, 65536, 3), 0, e}};
    rows = {rows, row_t'{make_tri(7, 9, 0, 65536, 0, 65536, 0, 65536, -65536, 4), 0, e}};
    foreach (rows[i]) begin
      if (rows[i].has_exp) seg_q = {seg_q, rows[i].exp_seg};
      else predict_segments(rows[i].t);
      send_tri(rows[i].t);
    end
    drain();

    reg_write(REG_SPACING, 32'h0000_0000);
    reg_write(REG_LOWER, 32'h8000_0000);
    reg_write(REG_UPPER, 32'h7fff_ffff);
    reg_write(REG_REGION, 32'h1);
    rows.delete();
    rows = {rows, row_t'{make_tri(32'h7fffffff, 32'h80000000, 0, 32'h80000000,
                                  32'h7fffffff, 100, 0, 0, 20, 32'h7fffffff), 0, e}};
    rows = {rows, row_t'{make_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                  32'h7fffffff, 32'h7fffffff, 0, 0, 0, 32'h80000000), 0, e}};
    rows = {rows, row_t'{make_tri(-5, 3, 40000, 9, -3, 40001, 1, 1, 40070, -1), 0, e}};
    foreach (rows[i]) begin
      predict_segments(rows[i].t);
      send_tri(rows[i].t);
    end
    drain();

    reg_write(REG_SPACING, 32'h7fff_ffff);
    reg_write(REG_LOWER, 32'h8000_0000);
    reg_write(REG_UPPER, 32'h7fff_ffff);
    random_phase(40, 0, 0);

    reg_write(REG_SPACING, 32'h0000_8000);
    reg_write(REG_LOWER, 32'hfff0_0000);
    reg_write(REG_UPPER, 32'h0010_0000);
    reg_write(REG_REGION, 32'h0);
    random_phase(110, 0, 0);

    reg_write(REG_SPACING, 32'h0001_0000);
    reg_write(REG_LOWER, 32'hfffd_0000);
    reg_write(REG_UPPER, 32'h0003_0000);
    reg_write(REG_REGION, 32'h1);
    random_phase(110, 73, 0);

    // crossed bounds
    reg_write(REG_LOWER, 32'h0002_0000);
    reg_write(REG_UPPER, 32'hfffe_0000);
    random_phase(30, 0, 73);

    reg_write(REG_SPACING, 32'h0000_3000);
    reg_write(REG_LOWER, 32'hffec_0000);
    reg_write(REG_UPPER, 32'h0014_0000);
    random_phase(90, 0, 73);

    reg_write(REG_SPACING, 32'h0002_0000);
    reg_write(REG_LOWER, 32'hfffc_0000);
    reg_write(REG_UPPER, 32'h0004_0000);
    reg_write(REG_REGION, 32'h0);
    random_phase(100, 18, 18);

    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tps_pkg.sv
hw/rtl/tps_tri_if.sv
hw/rtl/tps_seg_if.sv
hw/rtl/tps_front.sv
hw/rtl/tps_queue.sv
hw/rtl/tps_back.sv
hw/rtl/triangle_plane_slicer_core.sv
tb/tb_triangle_plane_slicer_core.sv
